// ===== src/assoc_tlb_lru_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the associative TLB
// Clocked property checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSOC_TLB_LRU_MACROS_SVH
`define ASSOC_TLB_LRU_MACROS_SVH

`ifndef ASSERT_OFF
`define ATLB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ATLB_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ATLB_ASSERT(label, clk, rst, prop, msg)
`define ATLB_ASSERT_NORST(label, clk, prop, msg)
`endif

`endif

// ===== src/atlb_pkg.sv =====
// ----------------------------------------------------------------------------
// atlb_pkg
// Types and constants shared by the associative TLB modules.
// ----------------------------------------------------------------------------
package atlb_pkg;

   localparam int ENTRIES  = 64;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int N_W      = $clog2(ENTRIES + 1);
   localparam int CNT_W    = 7;
   localparam int EXT_W    = (N_W > CNT_W) ? N_W : CNT_W;
   localparam int RANK_W   = 7;
   localparam logic [RANK_W-1:0] RANK_MAX = 7'd127;
   localparam int PAGE_W   = 32;
   localparam int ASID_W   = 8;
   localparam int CMD_W    = 2;
   localparam int SLOT_W   = 6;
   localparam int GRP      = 8;
   localparam int NGRP     = (ENTRIES + GRP - 1) / GRP;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_ASID     = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_FLUSH  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_PICK   = 2'd2,
      S_COMMIT = 2'd3
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic pick;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } dp_status_type;

endpackage

// ===== src/atlb_ctrl.sv =====
// ----------------------------------------------------------------------------
// atlb_ctrl
// Sequencer that steps each request through scan, pick and commit.
// ----------------------------------------------------------------------------
`include "assoc_tlb_lru_macros.svh"

module atlb_ctrl
   import atlb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_SCAN;
         S_SCAN:   state_in = S_PICK;
         S_PICK:   state_in = S_COMMIT;
         S_COMMIT: if (status.rsp_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = (state_ff == S_IDLE);
      cmd.capture = (state_ff == S_IDLE) && req_tvalid;
      cmd.scan    = (state_ff == S_SCAN);
      cmd.pick    = (state_ff == S_PICK);
      cmd.commit  = (state_ff == S_COMMIT) && status.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ATLB_ASSERT(a_accept_to_scan, clock, reset,
                (req_tvalid && req_tready) |=> (state_ff == S_SCAN),
                "accepted request did not start a scan")
   `ATLB_ASSERT(a_one_step, clock, reset,
                $onehot0({cmd.capture, cmd.scan, cmd.pick, cmd.commit}),
                "more than one datapath step in a cycle")
   `ATLB_ASSERT(a_commit_free, clock, reset,
                cmd.commit |-> status.rsp_free,
                "commit while the result register is occupied")

endmodule

// ===== src/atlb_dp.sv =====
// ----------------------------------------------------------------------------
// atlb_dp
// Tag store, valid bits, recency ranks, selection logic and result register.
// ----------------------------------------------------------------------------
`include "assoc_tlb_lru_macros.svh"

module atlb_dp
   import atlb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [PAGE_W-1:0]     req_page,
   input  logic [ASID_W-1:0]     req_asid,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_hit,
   output logic [SLOT_W-1:0]     rsp_slot
);

   logic [CNT_W-1:0]  entries_ff;
   logic              match_ff;
   logic [CMD_W-1:0]  cmd_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [ASID_W-1:0] asid_ff;

   logic [PAGE_W-1:0] page_mem [ENTRIES];
   logic [ASID_W-1:0] asid_mem [ENTRIES];

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [RANK_W-1:0]  rank_ff [ENTRIES];
   logic [RANK_W-1:0]  rank_in [ENTRIES];

   logic [ENTRIES-1:0] match_vec_ff, match_vec_in;
   logic [ENTRIES-1:0] inval_vec_ff, inval_vec_in;
   logic [RANK_W-1:0]  grp_rank_ff [NGRP];
   logic [RANK_W-1:0]  grp_rank_in [NGRP];
   logic [IDX_W-1:0]   grp_idx_ff  [NGRP];
   logic [IDX_W-1:0]   grp_idx_in  [NGRP];
   logic [NGRP-1:0]    grp_vld_ff, grp_vld_in;

   logic [IDX_W-1:0]   target_ff, target_in;
   logic               hit_ff, hit_in;
   logic               upd_ff, upd_in;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;

   logic [N_W-1:0]     n_eff;
   logic [EXT_W-1:0]   n_ext;
   logic [ENTRIES-1:0] active;

   always_comb begin
      n_ext = EXT_W'(entries_ff);
      if (n_ext == '0) begin
         n_eff = N_W'(1);
      end else if (n_ext > EXT_W'(ENTRIES)) begin
         n_eff = N_W'(ENTRIES);
      end else begin
         n_eff = N_W'(n_ext);
      end
      for (int e = 0; e < ENTRIES; e++) begin
         active[e] = (N_W'(e) < n_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= CNT_W'(ENTRIES);
         match_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENTRIES_IN_USE: entries_ff <= csr_wdata[CNT_W-1:0];
            CSR_MATCH_ASID:     match_ff   <= csr_wdata[0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_cmd;
         page_ff <= req_page;
         asid_ff <= req_asid;
      end
   end

   // Scan: per-entry compare and per-group oldest entry.
   always_comb begin
      logic [RANK_W-1:0] best;
      logic [IDX_W-1:0]  bidx;
      logic              gv;
      int                e;
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec_in[i] = active[i] && valid_ff[i] && (page_mem[i] == page_ff)
                           && (!match_ff || (asid_mem[i] == asid_ff));
         inval_vec_in[i] = active[i] && !valid_ff[i];
      end
      for (int g = 0; g < NGRP; g++) begin
         best = '0;
         bidx = '0;
         gv   = 1'b0;
         for (int k = 0; k < GRP; k++) begin
            e = g * GRP + k;
            if (e < ENTRIES) begin
               if (active[e] && (rank_ff[e] >= best)) begin
                  best = rank_ff[e];
                  bidx = IDX_W'(e);
                  gv   = 1'b1;
               end
            end
         end
         grp_rank_in[g] = best;
         grp_idx_in[g]  = bidx;
         grp_vld_in[g]  = gv;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         match_vec_ff <= match_vec_in;
         inval_vec_ff <= inval_vec_in;
         grp_rank_ff  <= grp_rank_in;
         grp_idx_ff   <= grp_idx_in;
         grp_vld_ff   <= grp_vld_in;
      end
   end

   // Pick: lowest match, lowest free entry, or oldest entry.
   always_comb begin
      logic [IDX_W-1:0]  m_idx;
      logic              m_any;
      logic [IDX_W-1:0]  f_idx;
      logic              f_any;
      logic [RANK_W-1:0] best;
      logic [IDX_W-1:0]  o_idx;
      m_idx = '0;
      m_any = 1'b0;
      f_idx = '0;
      f_any = 1'b0;
      for (int e = ENTRIES - 1; e >= 0; e--) begin
         if (match_vec_ff[e]) begin
            m_idx = IDX_W'(e);
            m_any = 1'b1;
         end
         if (inval_vec_ff[e]) begin
            f_idx = IDX_W'(e);
            f_any = 1'b1;
         end
      end
      best  = '0;
      o_idx = '0;
      for (int g = 0; g < NGRP; g++) begin
         if (grp_vld_ff[g] && (grp_rank_ff[g] >= best)) begin
            best  = grp_rank_ff[g];
            o_idx = grp_idx_ff[g];
         end
      end
      target_in = '0;
      hit_in    = 1'b0;
      upd_in    = 1'b0;
      unique case (cmd_ff)
         CMD_LOOKUP: begin
            target_in = m_idx;
            hit_in    = m_any;
            upd_in    = m_any;
         end
         CMD_INSERT: begin
            target_in = f_any ? f_idx : o_idx;
            upd_in    = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         target_ff <= target_in;
         hit_ff    <= hit_in;
         upd_ff    <= upd_in;
      end
   end

   // Commit: rank update, valid bits and stores.
   always_comb begin
      logic [RANK_W-1:0] base;
      base     = rank_ff[target_ff];
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (cmd.commit) begin
         if (upd_ff) begin
            for (int e = 0; e < ENTRIES; e++) begin
               if (active[e] && (rank_ff[e] <= base) && (rank_ff[e] != RANK_MAX)) begin
                  rank_in[e] = rank_ff[e] + RANK_W'(1);
               end
            end
            rank_in[target_ff] = '0;
         end
         if (cmd_ff == CMD_FLUSH) begin
            valid_in = '0;
         end else if (cmd_ff == CMD_INSERT) begin
            valid_in[target_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int e = 0; e < ENTRIES; e++) begin
            rank_ff[e] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && (cmd_ff == CMD_INSERT)) begin
         page_mem[target_ff] <= page_ff;
         asid_mem[target_ff] <= asid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff  <= hit_ff;
         rsp_slot_ff <= (hit_ff || (cmd_ff == CMD_INSERT)) ? SLOT_W'(target_ff) : '0;
      end
   end

   assign status.rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_slot        = rsp_slot_ff;

   `ATLB_ASSERT(a_insert_sets_valid, clock, reset,
                (cmd.commit && (cmd_ff == CMD_INSERT)) |=> valid_ff[target_ff],
                "inserted entry is not valid")
   `ATLB_ASSERT(a_recent_rank_zero, clock, reset,
                (cmd.commit && upd_ff) |=> (rank_ff[target_ff] == '0),
                "most recent entry does not hold rank zero")
   `ATLB_ASSERT(a_flush_clears, clock, reset,
                (cmd.commit && (cmd_ff == CMD_FLUSH)) |=> (valid_ff == '0),
                "flush left a valid entry")

endmodule

// ===== src/assoc_tlb_lru.sv =====
// ----------------------------------------------------------------------------
// assoc_tlb_lru
// Fully associative TLB tag store with rank-based LRU replacement.
//
// Requests arrive on the req_ channel: tuser carries the command (lookup,
// insert or flush), tdata the page number and ASID. Each request yields
// exactly one response on the rsp_ channel: tuser is the hit flag, tdata
// the slot. The csr_ port writes the entries-in-use count and the ASID
// match enable; the user must write it only while the block is idle, as
// the block itself does not enforce this. A request is captured, then
// goes through the parallel tag compare and the per-group oldest-entry
// search, then the priority and final oldest-entry selection, and last
// the update of ranks, valid bits and tags while loading the response
// register. The next request is taken in the cycle after that commit, so
// a new request is not accepted before the last one has committed. A
// response waits in its output register while the receiver stalls; the
// next request is still accepted and held at its commit step until the
// register frees. Reset clears all valid bits and ranks, and sets 64
// entries in use with ASID matching on.
// ----------------------------------------------------------------------------
module assoc_tlb_lru
   import atlb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,   // page_number[31:0], asid[39:32]
   input  logic [CMD_W-1:0]      req_tuser,   // cmd[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // slot[5:0], zero[7:6]
   output logic                  rsp_tuser,   // hit[0]
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [SLOT_W-1:0] slot;

   atlb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   atlb_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_cmd    (req_tuser),
      .req_page   (req_tdata[31:0]),
      .req_asid   (req_tdata[39:32]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_hit    (rsp_tuser),
      .rsp_slot   (slot)
   );

   assign rsp_tdata = {2'b00, slot};

endmodule
